// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pedal plausibility block.
// Every user module has a clock named clk and an active-low reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dspp_pkg.sv =====
// ---------------------------------------------------------------------------
// Dual-sensor pedal plausibility package
// Widths, fixed-point constants, register codes, payload types and the
// command and status groups shared between controller and datapath.
// ---------------------------------------------------------------------------
package dspp_pkg;

    // Basic widths and limits.
    localparam int ADC_BITS    = 12;
    localparam int FRAC_BITS   = 16;
    localparam int PEDAL_BITS  = 12;
    localparam int CNT_W       = 6;
    localparam int ERROR_CAP   = 50;
    localparam int ERROR_TRIP  = 10;
    localparam int CFG_IDX_W   = 3;

    // Normalized fractions: magnitude quotient and its signed form.
    localparam int NUM_W       = ADC_BITS + FRAC_BITS;
    localparam int FX_W        = NUM_W + 1;
    localparam int QCNT_W      = $clog2(NUM_W);
    localparam int FX_ONE      = 1 << FRAC_BITS;
    localparam int FX_TENTH    = (FX_ONE + 5) / 10;
    localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
    localparam int PEDAL_MAX   = (1 << PEDAL_BITS) - 1;

    // Output scaling: 20*a - ONE is at most 19*ONE, so FRAC_BITS + 5 bits.
    localparam int SC_W        = FRAC_BITS + 5;
    localparam int PROD_W      = SC_W + PEDAL_BITS;
    localparam int Y_W         = PROD_W - FRAC_BITS;

    // Division by 19 as a reciprocal multiply; exact for y below 4095*19.
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_19    = ((1 << RECIP_SHIFT) + 18) / 19;
    localparam int RECIP_W     = 18;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TORQUE_SENSOR_LOW   = 0,
        REG_TORQUE_SENSOR_HIGH  = 1,
        REG_TORQUE_INVERSE_LOW  = 2,
        REG_TORQUE_INVERSE_HIGH = 3,
        REG_BRAKE_SENSOR_LOW    = 4,
        REG_BRAKE_SENSOR_HIGH   = 5,
        REG_BRAKE_INVERSE_LOW   = 6,
        REG_BRAKE_INVERSE_HIGH  = 7
    } cfg_reg_t;

    // Classification codes.
    typedef enum logic [1:0] {
        PS_OK          = 2'd0,
        PS_UNDER       = 2'd1,
        PS_IMPLAUSIBLE = 2'd2,
        PS_OVER        = 2'd3
    } pair_state_t;

    // Calibration end points of one pedal.
    typedef struct packed {
        logic [ADC_BITS-1:0] sensor_low;
        logic [ADC_BITS-1:0] sensor_high;
        logic [ADC_BITS-1:0] inverse_low;
        logic [ADC_BITS-1:0] inverse_high;
    } cal_set_t;

    // Input transaction payload.
    typedef struct packed {
        logic                pair_select;
        logic [ADC_BITS-1:0] sensor_raw;
        logic [ADC_BITS-1:0] inverted_raw;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic                  pair_index;
        logic [1:0]            pair_state;
        logic [PEDAL_BITS-1:0] pedal_value;
        logic                  report_valid;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic classify;
        logic scale;
        logic mul;
        logic commit;
    } dspp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } dspp_status_t;

endpackage

// ===== hdl/dspp_div.sv =====
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per clock, NUM_W steps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dspp_div
    import dspp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    dividend,
    input  logic [ADC_BITS-1:0] divisor,
    output logic                done,
    output logic [NUM_W-1:0]    quotient
);

    localparam logic [QCNT_W-1:0] LAST_STEP = QCNT_W'(NUM_W - 1);

    logic                busy_reg, busy_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [ADC_BITS-1:0] rem_reg, rem_next;
    logic [ADC_BITS-1:0] dvs_reg, dvs_next;
    logic [ADC_BITS:0]   shifted;
    logic [ADC_BITS:0]   trial;
    logic                fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = !trial[ADC_BITS];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + QCNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == LAST_STEP);
    assign quotient = quo_reg;

    // The last step is signaled once, and the unit is idle afterwards.
    `ASSERT_NEXT(a_div_done_once, done, !busy_reg && !done, "divider did not stop after last step")

endmodule

// ===== hdl/dspp_dpath.sv =====
// ---------------------------------------------------------------------------
// Pedal plausibility datapath
// Calibration registers, normalization by two serial dividers, range
// classification, output scaling, per-pedal error counters and the
// output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dspp_dpath
    import dspp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADC_BITS-1:0]  cfg_data,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  dspp_cmd_t            cmd,
    output dspp_status_t         status
);

    localparam logic signed [FX_W:0] TENTH_P = (FX_W + 1)'(FX_TENTH);
    localparam logic signed [FX_W:0] TENTH_N = -TENTH_P;
    localparam logic signed [FX_W:0] ONE_P   = (FX_W + 1)'(FX_ONE);
    localparam logic signed [FX_W:0] OVER_P  = (FX_W + 1)'(FX_ONE + FX_TENTH);
    localparam logic [FRAC_BITS:0]   ONE_C   = (FRAC_BITS + 1)'(FX_ONE);
    localparam logic [FRAC_BITS+5:0] ONE_T   = (FRAC_BITS + 6)'(FX_ONE);
    localparam logic [RECIP_W-1:0]   RECIP_C = RECIP_W'(RECIP_19);
    localparam logic [PEDAL_BITS-1:0] PEDAL_C = PEDAL_BITS'(PEDAL_MAX);
    localparam logic [CNT_W-1:0]     CAP_C   = CNT_W'(ERROR_CAP);
    localparam logic [CNT_W-1:0]     TRIP_C  = CNT_W'(ERROR_TRIP);
    localparam logic [ADC_BITS-1:0]  ADC_C   = ADC_BITS'(ADC_MAX);

    // Calibration registers, one set per pedal.
    cal_set_t torque_cal_reg;
    cal_set_t brake_cal_reg;

    // Per-item registers.
    logic                     pair_reg;
    logic                     neg_a_reg;
    logic                     neg_b_reg;
    logic                     zero_span_reg;
    pair_state_t              class_reg, class_next;
    logic [SC_W-1:0]          num_reg, num_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [PEDAL_BITS-1:0]    val_reg, val_next;

    // Pedal state.
    logic [CNT_W-1:0]         err_cnt_reg [2];
    logic [PEDAL_BITS-1:0]    held_reg [2];

    // Output register.
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    // Load-stage signals.
    cal_set_t                 cal_sel;
    logic [ADC_BITS:0]        num_a, span_a, num_b, span_b;
    logic [ADC_BITS-1:0]      mag_num_a, mag_span_a, mag_num_b, mag_span_b;
    logic [NUM_W-1:0]         dividend_a, dividend_b;
    logic                     done_a, done_b;
    logic [NUM_W-1:0]         quo_a, quo_b;

    // Classify-stage signals.
    logic signed [FX_W-1:0]   a_fx, b_fx;
    logic signed [FX_W:0]     a_wide, b_wide, ab_diff, ab_abs;
    logic [FRAC_BITS:0]       a_clamp;
    logic [FRAC_BITS+5:0]     times20;

    // Multiply-stage signals.
    logic [Y_W-1:0]           y_val;
    logic [Y_W+RECIP_W-1:0]   q_full;
    logic [Y_W+RECIP_W-RECIP_SHIFT-1:0] q_val;

    // Commit-stage signals.
    logic [CNT_W-1:0]         cnt_cur, cnt_new;
    logic [PEDAL_BITS-1:0]    held_cur, held_new;
    logic                     report;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_cal_reg <= '{sensor_low: '0, sensor_high: ADC_C,
                               inverse_low: '0, inverse_high: ADC_C};
            brake_cal_reg  <= '{sensor_low: '0, sensor_high: ADC_C,
                               inverse_low: '0, inverse_high: ADC_C};
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TORQUE_SENSOR_LOW:   torque_cal_reg.sensor_low   <= cfg_data;
                REG_TORQUE_SENSOR_HIGH:  torque_cal_reg.sensor_high  <= cfg_data;
                REG_TORQUE_INVERSE_LOW:  torque_cal_reg.inverse_low  <= cfg_data;
                REG_TORQUE_INVERSE_HIGH: torque_cal_reg.inverse_high <= cfg_data;
                REG_BRAKE_SENSOR_LOW:    brake_cal_reg.sensor_low    <= cfg_data;
                REG_BRAKE_SENSOR_HIGH:   brake_cal_reg.sensor_high   <= cfg_data;
                REG_BRAKE_INVERSE_LOW:   brake_cal_reg.inverse_low   <= cfg_data;
                REG_BRAKE_INVERSE_HIGH:  brake_cal_reg.inverse_high  <= cfg_data;
            endcase
        end
    end

    // Offsets and spans as signed differences, split into sign and magnitude.
    always_comb
    begin
        cal_sel    = in_data.pair_select ? brake_cal_reg : torque_cal_reg;
        num_a      = {1'b0, in_data.sensor_raw} - {1'b0, cal_sel.sensor_low};
        span_a     = {1'b0, cal_sel.sensor_high} - {1'b0, cal_sel.sensor_low};
        num_b      = {1'b0, cal_sel.inverse_high} - {1'b0, in_data.inverted_raw};
        span_b     = {1'b0, cal_sel.inverse_high} - {1'b0, cal_sel.inverse_low};
        mag_num_a  = num_a[ADC_BITS]  ? ADC_BITS'(-num_a)  : num_a[ADC_BITS-1:0];
        mag_span_a = span_a[ADC_BITS] ? ADC_BITS'(-span_a) : span_a[ADC_BITS-1:0];
        mag_num_b  = num_b[ADC_BITS]  ? ADC_BITS'(-num_b)  : num_b[ADC_BITS-1:0];
        mag_span_b = span_b[ADC_BITS] ? ADC_BITS'(-span_b) : span_b[ADC_BITS-1:0];
        dividend_a = {mag_num_a, {FRAC_BITS{1'b0}}};
        dividend_b = {mag_num_b, {FRAC_BITS{1'b0}}};
    end

    // Sign and zero-span flags travel alongside the division.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pair_reg      <= in_data.pair_select;
            neg_a_reg     <= num_a[ADC_BITS] ^ span_a[ADC_BITS];
            neg_b_reg     <= num_b[ADC_BITS] ^ span_b[ADC_BITS];
            zero_span_reg <= (span_a == '0) || (span_b == '0);
        end
    end

    // Normal and inverted fractions are divided in parallel.
    dspp_div u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (dividend_a),
        .divisor  (mag_span_a),
        .done     (done_a),
        .quotient (quo_a)
    );

    dspp_div u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (dividend_b),
        .divisor  (mag_span_b),
        .done     (done_b),
        .quotient (quo_b)
    );

    // Classification in priority order, then clamp and deadband removal.
    always_comb
    begin
        a_fx    = neg_a_reg ? -{1'b0, quo_a} : {1'b0, quo_a};
        b_fx    = neg_b_reg ? -{1'b0, quo_b} : {1'b0, quo_b};
        a_wide  = {a_fx[FX_W-1], a_fx};
        b_wide  = {b_fx[FX_W-1], b_fx};
        ab_diff = a_wide - b_wide;
        ab_abs  = ab_diff[FX_W] ? -ab_diff : ab_diff;

        priority if (zero_span_reg)
            class_next = PS_IMPLAUSIBLE;
        else if (ab_abs > TENTH_P)
            class_next = PS_IMPLAUSIBLE;
        else if ((a_wide < TENTH_N) || (b_wide < TENTH_N))
            class_next = PS_UNDER;
        else if ((a_wide > OVER_P) || (b_wide > OVER_P))
            class_next = PS_OVER;
        else
            class_next = PS_OK;

        priority if (a_wide > ONE_P)
            a_clamp = ONE_C;
        else if (a_wide[FX_W])
            a_clamp = '0;
        else
            a_clamp = a_wide[FRAC_BITS:0];

        times20  = {1'b0, a_clamp, 4'b0000} + {3'b000, a_clamp, 2'b00};
        num_next = (times20 > ONE_T) ? SC_W'(times20 - ONE_T) : '0;
    end

    // Drop the fraction of the product scaled by 4095, divide by 19 via reciprocal, and limit to PEDAL_MAX.
    always_comb
    begin
        y_val    = prod_reg[PROD_W-1:FRAC_BITS];
        q_full   = {{RECIP_W{1'b0}}, y_val} * {{Y_W{1'b0}}, RECIP_C};
        q_val    = q_full[Y_W+RECIP_W-1:RECIP_SHIFT];
        val_next = (q_val > {1'b0, PEDAL_C}) ? PEDAL_C : q_val[PEDAL_BITS-1:0];
    end

    // Arithmetic pipeline registers, each loaded by its own command.
    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            class_reg <= class_next;
            num_reg   <= num_next;
        end
        if (cmd.scale)
        begin
            prod_reg <= {num_reg, {PEDAL_BITS{1'b0}}} - {{PEDAL_BITS{1'b0}}, num_reg};
        end
        if (cmd.mul)
        begin
            val_reg <= val_next;
        end
    end

    // Error counter update and report decision for the selected pedal.
    always_comb
    begin
        cnt_cur  = err_cnt_reg[pair_reg];
        held_cur = held_reg[pair_reg];
        cnt_new  = cnt_cur;
        report   = 1'b0;
        if (class_reg != PS_OK)
        begin
            if (cnt_cur < CAP_C)
            begin
                cnt_new = cnt_cur + CNT_W'(1);
            end
            report = (cnt_new > TRIP_C);
        end
        else if (cnt_cur != '0)
        begin
            cnt_new = cnt_cur - CNT_W'(1);
            report  = 1'b1;
        end
        if (report)
            held_new = '0;
        else if (class_reg == PS_OK)
            held_new = val_reg;
        else
            held_new = held_cur;
    end

    // Pedal state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_cnt_reg[0] <= '0;
            err_cnt_reg[1] <= '0;
            held_reg[0]    <= '0;
            held_reg[1]    <= '0;
        end
        else if (cmd.commit)
        begin
            err_cnt_reg[pair_reg] <= cnt_new;
            held_reg[pair_reg]    <= held_new;
        end
    end

    // Output register: holds a finished transaction until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg.pair_index   <= pair_reg;
            out_data_reg.pair_state   <= class_reg;
            out_data_reg.pedal_value  <= held_new;
            out_data_reg.report_valid <= report;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.div_done = done_a && done_b;
    assign status.out_free = !out_valid_reg || !out_stall;

    // A report always leaves the pedal value at zero.
    `ASSERT_NEXT(a_report_zero, cmd.commit && report, out_data_reg.report_valid && (out_data_reg.pedal_value == '0), "report without zero pedal value")

    // The error counters never pass their cap.
    `ASSERT_ALWAYS(a_cnt_capped, (err_cnt_reg[0] <= CAP_C) && (err_cnt_reg[1] <= CAP_C), "error counter above cap")

endmodule

// ===== hdl/dspp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Pedal plausibility controller
// Sequences one sample pair through load, division, classification, scaling,
// multiply and commit, and holds off input while a pair is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dspp_ctrl
    import dspp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  dspp_status_t status,
    output dspp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIV      = 6'b000010,
        ST_CLASSIFY = 6'b000100,
        ST_SCALE    = 6'b001000,
        ST_MUL      = 6'b010000,
        ST_COMMIT   = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Wait for room in the output register.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // The dividers finish only while the controller waits for them.
    `ASSERT_ALWAYS(a_done_in_div, !status.div_done || (state_reg == ST_DIV), "divider finished outside division state")

endmodule

// ===== hdl/dual_sensor_pedal_plausibility_top.sv =====
// ---------------------------------------------------------------------------
// Dual-sensor pedal plausibility check, top level
// Each input transaction carries one normal and one inverted sensor
// reading for the torque or brake pedal and yields exactly one output
// transaction. One pair is processed at a time. The two 28-step serial
// dividers (one quotient bit per cycle) that normalize the readings take
// most of the time to a result, and the classify, scale, multiply and
// commit states follow them. The next pair is accepted the cycle after
// the result enters the output register, even while that result still
// waits to be taken; a new pair is never taken before the previous result
// is committed. A result that is still stalled when the next one is ready
// holds back the commit, and with it the next pair. Calibration registers
// are to be written through the plain write port only while the block is
// idle; keeping to this is up to the user, as the block has no check for it.
// ---------------------------------------------------------------------------
module dual_sensor_pedal_plausibility_top
    import dspp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADC_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    dspp_cmd_t    cmd;
    dspp_status_t status;

    // Sequencing.
    dspp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, pedal state and output register.
    dspp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
